[rtl/core/srmt_pkg.sv]
// ----------------------------------------------------------------------------
// srmt_pkg
// Shared types and constants of the sparse row map table.
// ----------------------------------------------------------------------------
package srmt_pkg;

    // fixed field widths of the command and result ports
    localparam int ROW_W    = 12;
    localparam int ROWE_W   = 13;
    localparam int IN_COL_W = 16;
    localparam int END_COL_W = 17;
    localparam int SCORE_W  = 32;
    localparam int REGS_W   = 16;
    localparam int REGE_W   = 17;

    // largest number of rows that a row index can address
    localparam int ROW_SPAN = 4096;

    // command codes
    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_GET      = 3'd2,
        OP_MAP      = 3'd3,
        OP_CLR_ROWS = 3'd4,
        OP_CLR_COLS = 3'd5,
        OP_CLR_ALL  = 3'd6
    } op_t;

    // map search modes
    localparam logic [1:0] MODE_EXACT = 2'd0;
    localparam logic [1:0] MODE_LEFT  = 2'd1;
    localparam logic [1:0] MODE_RIGHT = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_GET,
        ST_MAP,
        ST_COLS,
        ST_RESCAN
    } state_t;

endpackage

[rtl/core/srmt_ram.sv]
// ----------------------------------------------------------------------------
// srmt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module srmt_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/sparse_row_map_table.sv]
// ----------------------------------------------------------------------------
// sparse_row_map_table
// Direct-mapped table of row/column pairs with tracked row and column bounds.
// ----------------------------------------------------------------------------
// Usage: a command transaction is taken at a rising edge with start high and
// busy low; opcode and its operand ports are sampled then. Exactly one result
// follows per command: done is high for one cycle while found, result_col and
// result_score hold the answer and is_empty, first_row, end_row, first_col and
// end_col show the bounds after the command. The receiver cannot stall: the
// result must be taken in its done cycle. A new command may start in the done
// cycle.
// Per command (R = number of rows kept, min(ROW_DEPTH, 4096)):
//   add, unused code, empty clear cols      busy stays low
//   get                                     read of the addressed row
//   map                                     one row read per cycle through
//                                           the single read port
//   remove                                  bound rescan
//   clear rows                              window rows, then bound rescan
//   clear cols                              occupied span, then bound rescan
//   clear all                               one row written per cycle
// The rate is set by the one read and one write port of the pair memory.
// After reset the block sweeps all R rows to clear them, with busy high,
// before it takes its first command.
// ----------------------------------------------------------------------------
module sparse_row_map_table
    import srmt_pkg::*;
#(
    parameter int ROW_DEPTH = 4096,
    parameter int COL_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           opcode,
    input  logic [ROW_W-1:0]     row_index,
    input  logic [IN_COL_W-1:0]  col_value,
    input  logic [SCORE_W-1:0]   score_word,
    input  logic [1:0]           search_mode,
    input  logic [REGS_W-1:0]    region_start,
    input  logic [REGE_W-1:0]    region_end,
    output logic                 done,
    output logic                 found,
    output logic [IN_COL_W-1:0]  result_col,
    output logic [SCORE_W-1:0]   result_score,
    output logic                 is_empty,
    output logic [ROW_W-1:0]     first_row,
    output logic [ROWE_W-1:0]    end_row,
    output logic [IN_COL_W-1:0]  first_col,
    output logic [END_COL_W-1:0] end_col
);

    localparam int SCAN_ROWS = (ROW_DEPTH < ROW_SPAN) ? ROW_DEPTH : ROW_SPAN;
    localparam int AW        = $clog2(SCAN_ROWS);
    localparam int ENT_W     = 1 + COL_WIDTH + SCORE_W;
    localparam int CMPW      = (COL_WIDTH + 1 > END_COL_W) ? COL_WIDTH + 1 : END_COL_W;
    localparam logic [ROWE_W-1:0] ROWS_N    = ROWE_W'(SCAN_ROWS);
    localparam logic [ROWE_W-1:0] ROWS_LAST = ROWE_W'(SCAN_ROWS - 1);

    // control registers
    state_t              state_reg, state_next;
    logic [ROWE_W-1:0]   addr_reg, addr_next;
    logic [ROWE_W-1:0]   last_reg, last_next;
    logic                down_reg, down_next;
    logic                more_reg, more_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [ROWE_W-1:0]   rd_row_reg, rd_row_next;
    logic                rescan_after_reg, rescan_after_next;
    logic                report_reg, report_next;
    logic                done_reg, done_next;

    // result and operand registers
    logic                found_reg, found_next;
    logic [IN_COL_W-1:0] res_col_reg, res_col_next;
    logic [SCORE_W-1:0]  res_score_reg, res_score_next;
    logic [REGS_W-1:0]   cs_reg, cs_next;
    logic [REGE_W-1:0]   ce_reg, ce_next;

    // bounds
    logic [ROW_W-1:0]     low_row_reg, low_row_next;
    logic [ROWE_W-1:0]    high_row_reg, high_row_next;
    logic [COL_WIDTH-1:0] low_col_reg, low_col_next;
    logic [COL_WIDTH:0]   high_col_reg, high_col_next;
    logic                 empty_reg, empty_next;

    // memory ports
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [ENT_W-1:0]  mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [ENT_W-1:0]  mem_rdata;

    // decoded command and read data
    op_t                  op;
    logic                 accept;
    logic [ROWE_W-1:0]    row13;
    logic [ROWE_W-1:0]    low13;
    logic                 row_ok;
    logic                 in_bounds;
    logic [COL_WIDTH-1:0] col_in;
    logic                 rd_valid;
    logic [COL_WIDTH-1:0] rd_col;
    logic [SCORE_W-1:0]   rd_score;
    logic [CMPW-1:0]      rd_col_x;
    logic                 hit_now;
    logic                 issue;
    logic                 last_issue;
    logic                 drained;
    logic                 cols_clear;
    logic                 sweep_last;
    logic                 go_rescan;

    // map decision
    logic                 map_go;
    logic [ROWE_W-1:0]    map_s;
    logic [ROWE_W-1:0]    map_last;
    logic                 map_down;

    // clear rows window
    logic [REGS_W-1:0]    rows_s;
    logic [REGE_W-1:0]    rows_e;
    logic [REGE_W-1:0]    rows_e_m1;
    logic                 rows_go;

    // bound update
    logic                 upd_en;
    logic [ROW_W-1:0]     upd_row;
    logic [COL_WIDTH-1:0] upd_col;
    logic                 clr_bounds;

    // output extension
    logic [CMPW-1:0]      low_col_x;
    logic [CMPW-1:0]      high_col_x;

    // pair memory: valid, column, score
    srmt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SCAN_ROWS)
    ) u_pair_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // decode the command and the returned entry
    assign op        = op_t'(opcode);
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign row13     = {1'b0, row_index};
    assign low13     = {1'b0, low_row_reg};
    assign row_ok    = row13 < ROWS_N;
    assign in_bounds = (row13 >= low13) && (row13 < high_row_reg);
    assign col_in    = COL_WIDTH'(col_value);
    assign rd_valid  = mem_rdata[ENT_W-1];
    assign rd_col    = mem_rdata[COL_WIDTH+SCORE_W-1:SCORE_W];
    assign rd_score  = mem_rdata[SCORE_W-1:0];
    assign rd_col_x  = CMPW'(rd_col);

    // scan handshake between issued reads and returned data
    assign hit_now    = (state_reg == ST_MAP) && rd_vld_reg && rd_valid;
    assign issue      = more_reg && !hit_now &&
                        ((state_reg == ST_MAP) || (state_reg == ST_COLS) ||
                         (state_reg == ST_RESCAN));
    assign last_issue = issue && (addr_reg == last_reg);
    assign drained    = !more_reg && !rd_vld_reg;
    assign cols_clear = (state_reg == ST_COLS) && rd_vld_reg && rd_valid &&
                        (rd_col_x >= CMPW'(cs_reg)) && (rd_col_x < CMPW'(ce_reg));
    assign sweep_last = (addr_reg == last_reg);
    assign go_rescan  = (state_next == ST_RESCAN) && (state_reg != ST_RESCAN);

    // choose the first row and the search limit of a map
    always_comb
    begin
        map_go   = 1'b0;
        map_s    = '0;
        map_last = '0;
        map_down = 1'b0;
        if (!empty_reg && row_ok)
        begin
            if ((search_mode == MODE_LEFT) && (row13 >= high_row_reg))
            begin
                map_go   = 1'b1;
                map_s    = high_row_reg - ROWE_W'(1);
                map_last = high_row_reg - ROWE_W'(1);
            end
            else if ((search_mode == MODE_RIGHT) && (row13 < low13))
            begin
                map_go   = 1'b1;
                map_s    = low13;
                map_last = low13;
            end
            else if (in_bounds)
            begin
                map_go = 1'b1;
                map_s  = row13;
                case (search_mode)
                    MODE_LEFT:
                    begin
                        map_last = low13;
                        map_down = 1'b1;
                    end
                    MODE_RIGHT:
                    begin
                        map_last = high_row_reg - ROWE_W'(1);
                    end
                    default:
                    begin
                        map_last = row13;
                    end
                endcase
            end
        end
    end

    // clamp the row window of a clear rows command
    always_comb
    begin
        rows_s    = (region_start < REGS_W'(low_row_reg)) ? REGS_W'(low_row_reg) : region_start;
        rows_e    = (region_end > REGE_W'(high_row_reg)) ? REGE_W'(high_row_reg) : region_end;
        rows_e_m1 = rows_e - REGE_W'(1);
        rows_go   = {1'b0, rows_s} < rows_e;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_ADD:      state_next = ST_IDLE;
                        OP_REMOVE:   state_next = ST_RESCAN;
                        OP_GET:      state_next = row_ok ? ST_GET : ST_IDLE;
                        OP_MAP:      state_next = map_go ? ST_MAP : ST_IDLE;
                        OP_CLR_ROWS: state_next = rows_go ? ST_SWEEP : ST_RESCAN;
                        OP_CLR_COLS: state_next = empty_reg ? ST_IDLE : ST_COLS;
                        OP_CLR_ALL:  state_next = ST_SWEEP;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = rescan_after_reg ? ST_RESCAN : ST_IDLE;
                end
            end
            ST_GET:
            begin
                state_next = ST_IDLE;
            end
            ST_MAP:
            begin
                if (hit_now || drained)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COLS:
            begin
                if (drained)
                begin
                    state_next = ST_RESCAN;
                end
            end
            ST_RESCAN:
            begin
                if (drained)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and result control
    always_comb
    begin
        addr_next         = addr_reg;
        last_next         = last_reg;
        down_next         = down_reg;
        more_next         = more_reg && !last_issue && !hit_now;
        rd_vld_next       = issue;
        rd_row_next       = addr_reg;
        rescan_after_next = rescan_after_reg;
        report_next       = report_reg;
        done_next         = 1'b0;
        found_next        = found_reg;
        res_col_next      = res_col_reg;
        res_score_next    = res_score_reg;
        cs_next           = cs_reg;
        ce_next           = ce_reg;
        mem_we            = 1'b0;
        mem_waddr         = addr_reg[AW-1:0];
        mem_wdata         = '0;
        mem_raddr         = addr_reg[AW-1:0];
        upd_en            = 1'b0;
        upd_row           = rd_row_reg[ROW_W-1:0];
        upd_col           = rd_col;
        clr_bounds        = 1'b0;

        // advance the scan address
        if (issue)
        begin
            addr_next = down_reg ? addr_reg - ROWE_W'(1) : addr_reg + ROWE_W'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = row_index[AW-1:0];
                if (accept)
                begin
                    found_next     = 1'b0;
                    res_col_next   = '0;
                    res_score_next = '0;
                    cs_next        = region_start;
                    ce_next        = region_end;
                    unique case (op)
                        OP_ADD:
                        begin
                            done_next = 1'b1;
                            if (row_ok)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = row_index[AW-1:0];
                                mem_wdata = {1'b1, col_in, score_word};
                                upd_en    = 1'b1;
                                upd_row   = row_index;
                                upd_col   = col_in;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (row_ok && in_bounds)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = row_index[AW-1:0];
                            end
                        end
                        OP_GET:
                        begin
                            done_next = !row_ok;
                        end
                        OP_MAP:
                        begin
                            done_next = !map_go;
                            addr_next = map_s;
                            last_next = map_last;
                            down_next = map_down;
                            more_next = map_go;
                        end
                        OP_CLR_ROWS:
                        begin
                            addr_next         = ROWE_W'(rows_s);
                            last_next         = rows_e_m1[ROWE_W-1:0];
                            rescan_after_next = 1'b1;
                            report_next       = 1'b0;
                        end
                        OP_CLR_COLS:
                        begin
                            done_next = empty_reg;
                            addr_next = low13;
                            last_next = high_row_reg - ROWE_W'(1);
                            down_next = 1'b0;
                            more_next = !empty_reg;
                        end
                        OP_CLR_ALL:
                        begin
                            addr_next         = '0;
                            last_next         = ROWS_LAST;
                            rescan_after_next = 1'b0;
                            report_next       = 1'b1;
                            clr_bounds        = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + ROWE_W'(1);
                if (sweep_last && !rescan_after_reg && report_reg)
                begin
                    done_next = 1'b1;
                end
            end
            ST_GET:
            begin
                found_next     = rd_valid;
                res_col_next   = rd_valid ? rd_col_x[IN_COL_W-1:0] : '0;
                res_score_next = rd_valid ? rd_score : '0;
                done_next      = 1'b1;
            end
            ST_MAP:
            begin
                if (hit_now)
                begin
                    found_next   = 1'b1;
                    res_col_next = rd_col_x[IN_COL_W-1:0];
                    done_next    = 1'b1;
                end
                else if (drained)
                begin
                    done_next = 1'b1;
                end
            end
            ST_COLS:
            begin
                // drop matching pairs in the cycle after their read
                if (cols_clear)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_row_reg[AW-1:0];
                end
            end
            ST_RESCAN:
            begin
                if (rd_vld_reg && rd_valid)
                begin
                    upd_en = 1'b1;
                end
                if (drained)
                begin
                    done_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // start a bound rescan over every row
        if (go_rescan)
        begin
            addr_next  = '0;
            last_next  = ROWS_LAST;
            down_next  = 1'b0;
            more_next  = 1'b1;
            clr_bounds = 1'b1;
        end
    end

    // clear or widen the bounds
    always_comb
    begin
        low_row_next  = low_row_reg;
        high_row_next = high_row_reg;
        low_col_next  = low_col_reg;
        high_col_next = high_col_reg;
        empty_next    = empty_reg;
        if (clr_bounds)
        begin
            low_row_next  = '0;
            high_row_next = '0;
            low_col_next  = '0;
            high_col_next = '0;
            empty_next    = 1'b1;
        end
        else if (upd_en)
        begin
            if (empty_reg)
            begin
                low_row_next  = upd_row;
                high_row_next = {1'b0, upd_row} + ROWE_W'(1);
                low_col_next  = upd_col;
                high_col_next = {1'b0, upd_col} + (COL_WIDTH+1)'(1);
                empty_next    = 1'b0;
            end
            else
            begin
                if (upd_row < low_row_reg)
                begin
                    low_row_next = upd_row;
                end
                if (({1'b0, upd_row} + ROWE_W'(1)) > high_row_reg)
                begin
                    high_row_next = {1'b0, upd_row} + ROWE_W'(1);
                end
                if (upd_col < low_col_reg)
                begin
                    low_col_next = upd_col;
                end
                if (({1'b0, upd_col} + (COL_WIDTH+1)'(1)) > high_col_reg)
                begin
                    high_col_next = {1'b0, upd_col} + (COL_WIDTH+1)'(1);
                end
            end
        end
    end

    // control registers; reset starts the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_SWEEP;
            addr_reg         <= '0;
            last_reg         <= ROWS_LAST;
            down_reg         <= 1'b0;
            more_reg         <= 1'b0;
            rd_vld_reg       <= 1'b0;
            rescan_after_reg <= 1'b0;
            report_reg       <= 1'b0;
            done_reg         <= 1'b0;
            low_row_reg      <= '0;
            high_row_reg     <= '0;
            low_col_reg      <= '0;
            high_col_reg     <= '0;
            empty_reg        <= 1'b1;
        end
        else
        begin
            state_reg        <= state_next;
            addr_reg         <= addr_next;
            last_reg         <= last_next;
            down_reg         <= down_next;
            more_reg         <= more_next;
            rd_vld_reg       <= rd_vld_next;
            rescan_after_reg <= rescan_after_next;
            report_reg       <= report_next;
            done_reg         <= done_next;
            low_row_reg      <= low_row_next;
            high_row_reg     <= high_row_next;
            low_col_reg      <= low_col_next;
            high_col_reg     <= high_col_next;
            empty_reg        <= empty_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_row_reg    <= rd_row_next;
        found_reg     <= found_next;
        res_col_reg   <= res_col_next;
        res_score_reg <= res_score_next;
        cs_reg        <= cs_next;
        ce_reg        <= ce_next;
    end

    // drive the result ports
    assign low_col_x    = CMPW'(low_col_reg);
    assign high_col_x   = CMPW'(high_col_reg);
    assign done         = done_reg;
    assign found        = found_reg;
    assign result_col   = res_col_reg;
    assign result_score = res_score_reg;
    assign is_empty     = empty_reg;
    assign first_row    = low_row_reg;
    assign end_row      = high_row_reg;
    assign first_col    = low_col_x[IN_COL_W-1:0];
    assign end_col      = high_col_x[END_COL_W-1:0];

endmodule

[rtl/core/srmt_chk.sv]
// ----------------------------------------------------------------------------
// srmt_chk
// Port-level checks of the sparse row map table, bound to the top level.
// ----------------------------------------------------------------------------
module srmt_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        found,
    input logic        is_empty,
    input logic [11:0] first_row,
    input logic [12:0] end_row,
    input logic [15:0] first_col,
    input logic [16:0] end_col
);

    // a result is only shown while no command is in flight
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // an accepted transaction either finishes at once or holds busy
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction lost");

    // an empty table reports zero bounds
    a_empty_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        is_empty |-> (first_row == 12'd0 && end_row == 13'd0 &&
                      first_col == 16'd0 && end_col == 17'd0))
        else $error("bounds not zero on empty table");

    // an occupied table has a nonempty row range
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        !is_empty |-> ({1'b0, first_row} < end_row))
        else $error("row range inverted");

    // nothing can be found in an empty table
    a_found_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> !is_empty)
        else $error("hit reported on empty table");

endmodule

bind sparse_row_map_table srmt_chk u_srmt_chk (.*);
